// ----- design/jmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// jmpd_pkg
// Shared types, constants and arithmetic helpers for the joint-to-motor PWM
// decoupler.
// ----------------------------------------------------------------------------
package jmpd_pkg;

    // Number of joints and motors handled per item.
    localparam int MOTORS_MAX = 4;

    // Board kinds held in the board_kind register.
    localparam logic [2:0] BOARD_GENERIC   = 3'd0;
    localparam logic [2:0] BOARD_SHOULDER  = 3'd1;
    localparam logic [2:0] BOARD_WAIST     = 3'd2;
    localparam logic [2:0] BOARD_UPPER_LEG = 3'd3;
    localparam logic [2:0] BOARD_ANKLE     = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_BOARD_KIND  = 1'b0;
    localparam logic CFG_MOTOR_COUNT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [2:0] BOARD_KIND_RESET  = BOARD_GENERIC;
    localparam logic [2:0] MOTOR_COUNT_RESET = 3'd4;

    // Motor groups that are stopped and clamped together.
    localparam logic [3:0] GROUP_MASK = 4'h7;
    localparam logic [3:0] SOLO_MASK  = 4'h8;
    localparam logic [3:0] PAIR_MASK  = 4'h3;

    // Current clamps.
    localparam logic signed [15:0] SAFE_LIMIT    = 16'sd2500;
    localparam logic signed [15:0] NOMINAL_LIMIT = 16'sd6500;

    // Shoulder gain 65/40. A magnitude of at least SCALE_SAT_MAG saturates,
    // since 65 * 20165 / 40 is already past 32767. Below it, a / 40 is taken
    // as (a / 8) / 5, the division by five done with a reciprocal multiply
    // that is exact for every 18-bit dividend.
    localparam logic [33:0] SCALE_SAT_MAG = 34'd20165;
    localparam logic [18:0] RECIP_FIVE    = 19'd419431;

    // Input item.
    typedef struct packed {
        logic signed [31:0] joint_0;
        logic signed [31:0] joint_1;
        logic signed [31:0] joint_2;
        logic signed [31:0] joint_3;
        logic        [3:0]  fault_mask;
        logic        [3:0]  alarm_bits;
    } in_t;

    // Result item.
    typedef struct packed {
        logic signed [15:0] motor_pwm_0;
        logic signed [15:0] motor_pwm_1;
        logic signed [15:0] motor_pwm_2;
        logic signed [15:0] motor_pwm_3;
        logic        [3:0]  stopped_mask;
    } out_t;

    // Saturate a wide signed value to the 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767)
            r = 16'sh7fff;
        else if (v < -34'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Clamp a 16-bit value to +-lim.
    function automatic logic signed [15:0] limit16(input logic signed [15:0] v,
                                                   input logic signed [15:0] lim);
        logic signed [15:0] r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r;
    endfunction

    // Half of a signed value, rounded toward zero, then saturated.
    function automatic logic signed [15:0] half_sat(input logic signed [33:0] d);
        logic signed [33:0] h;
        h = (d + $signed({33'd0, d[33]})) >>> 1;
        return sat16(h);
    endfunction

    // 65 * d / 40 with truncation toward zero, saturated to 16 bits.
    function automatic logic signed [15:0] scale_sat(input logic signed [33:0] d);
        logic               neg;
        logic        [33:0] mag;
        logic        [20:0] prod65;
        logic        [17:0] eighth;
        logic        [36:0] recip;
        logic        [15:0] quot;
        logic signed [15:0] r;
        neg    = d[33];
        mag    = neg ? 34'(-d) : 34'(d);
        prod65 = {mag[14:0], 6'd0} + {6'd0, mag[14:0]};
        eighth = prod65[20:3];
        recip  = {19'd0, eighth} * {18'd0, RECIP_FIVE};
        quot   = recip[36:21];
        if (mag >= SCALE_SAT_MAG)
            r = neg ? 16'sh8000 : 16'sh7fff;
        else
            r = neg ? 16'(-quot) : 16'(quot);
        return r;
    endfunction

endpackage

// ----- design/joint_to_motor_pwm_decoupler.sv -----
// ----------------------------------------------------------------------------
// joint_to_motor_pwm_decoupler
// Maps four joint drive values to four motor PWM commands through a board
// specific decoupling matrix, with fault stops and current clamps.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the in channel (in_valid, in_stall, in_data) and results
// leave on the out channel (out_valid, out_stall, out_data), one result per
// item, in order. An item is taken at an edge where valid is high and stall
// is low.
// An item is held in an input register, the decoupling, saturation and
// clamps are worked out in one pass of logic, and the result is loaded into
// the output register when that register is empty or being emptied.
// Throughput is one item per cycle while the receiver does not stall; the
// pass through the shoulder gain multiply sets the clock period.
// When the receiver stalls, the result is held and the input register may
// still take one more item; in_stall rises only when both are full.
// The board_kind and motor_count registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no item is
// in flight, as the block does not enforce this. Reset empties both register
// stages and sets board_kind to generic and motor_count to four.
// ----------------------------------------------------------------------------
module joint_to_motor_pwm_decoupler
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  jmpd_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output jmpd_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [2:0]     cfg_data
);

    logic [2:0]     board_kind_reg;
    logic [2:0]     motor_count_reg;
    logic           s1_valid_reg;
    jmpd_pkg::in_t  s1_data_reg;
    logic           out_valid_reg;
    jmpd_pkg::out_t out_data_reg;
    jmpd_pkg::out_t out_data_next;

    logic out_ready;
    logic advance;
    logic in_take;

    logic signed [33:0] jnt [jmpd_pkg::MOTORS_MAX];
    logic signed [15:0] drv [jmpd_pkg::MOTORS_MAX];
    logic signed [15:0] pwm [jmpd_pkg::MOTORS_MAX];
    logic        [3:0]  stop_bits;
    logic        [3:0]  safe_en;
    logic        [3:0]  fault;
    logic        [3:0]  alarm;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_kind_reg  <= jmpd_pkg::BOARD_KIND_RESET;
            motor_count_reg <= jmpd_pkg::MOTOR_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == jmpd_pkg::CFG_BOARD_KIND)
                board_kind_reg <= cfg_data;
            else
                motor_count_reg <= cfg_data;
        end
    end

    // Handshake: the input register moves on whenever the output register is
    // empty or being emptied in this cycle.
    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

    // Decoupling matrix, fault stops and clamp enables per board kind.
    always_comb
    begin
        jnt[0] = 34'(s1_data_reg.joint_0);
        jnt[1] = 34'(s1_data_reg.joint_1);
        jnt[2] = 34'(s1_data_reg.joint_2);
        jnt[3] = 34'(s1_data_reg.joint_3);
        fault  = s1_data_reg.fault_mask;
        alarm  = s1_data_reg.alarm_bits;

        for (int i = 0; i < jmpd_pkg::MOTORS_MAX; i++)
        begin
            drv[i] = jmpd_pkg::sat16(jnt[i]);
        end
        stop_bits = 4'd0;
        safe_en   = 4'd0;

        unique case (board_kind_reg)
            jmpd_pkg::BOARD_SHOULDER:
            begin
                if ((fault & jmpd_pkg::GROUP_MASK) != 4'd0)
                begin
                    stop_bits = jmpd_pkg::GROUP_MASK;
                    drv[0]    = 16'sd0;
                    drv[1]    = 16'sd0;
                    drv[2]    = 16'sd0;
                end
                else
                begin
                    drv[1] = jmpd_pkg::scale_sat(jnt[1] - jnt[0]);
                    drv[2] = jmpd_pkg::scale_sat(jnt[1] - jnt[0] + jnt[2]);
                end
                if ((fault & jmpd_pkg::SOLO_MASK) != 4'd0)
                begin
                    stop_bits = stop_bits | jmpd_pkg::SOLO_MASK;
                    drv[3]    = 16'sd0;
                end
                safe_en = (alarm & jmpd_pkg::SOLO_MASK)
                        | (((alarm & jmpd_pkg::GROUP_MASK) != 4'd0)
                           ? jmpd_pkg::GROUP_MASK : 4'd0);
            end
            jmpd_pkg::BOARD_WAIST:
            begin
                if ((fault & jmpd_pkg::GROUP_MASK) != 4'd0)
                begin
                    stop_bits = jmpd_pkg::GROUP_MASK;
                    drv[0]    = 16'sd0;
                    drv[1]    = 16'sd0;
                    drv[2]    = 16'sd0;
                end
                else
                begin
                    drv[0] = jmpd_pkg::half_sat(jnt[0] - jnt[1]);
                    drv[1] = jmpd_pkg::half_sat(jnt[0] + jnt[1]);
                end
                drv[3]  = 16'sd0;
                safe_en = ((alarm & jmpd_pkg::GROUP_MASK) != 4'd0)
                          ? jmpd_pkg::GROUP_MASK : 4'd0;
            end
            jmpd_pkg::BOARD_UPPER_LEG:
            begin
                stop_bits = fault;
                safe_en   = alarm;
                for (int i = 0; i < jmpd_pkg::MOTORS_MAX; i++)
                begin
                    if (fault[i])
                        drv[i] = 16'sd0;
                end
            end
            jmpd_pkg::BOARD_ANKLE:
            begin
                stop_bits = fault & jmpd_pkg::PAIR_MASK;
                safe_en   = alarm & jmpd_pkg::PAIR_MASK;
                if (fault[0])
                    drv[0] = 16'sd0;
                if (fault[1])
                    drv[1] = 16'sd0;
                drv[2] = 16'sd0;
                drv[3] = 16'sd0;
            end
            default:
            begin
                // Generic and unknown kinds pass the joints straight through.
                stop_bits = 4'd0;
            end
        endcase
    end

    // Safe clamp on alarmed motors, then the nominal clamp on counted motors.
    always_comb
    begin
        for (int i = 0; i < jmpd_pkg::MOTORS_MAX; i++)
        begin
            pwm[i] = safe_en[i] ? jmpd_pkg::limit16(drv[i], jmpd_pkg::SAFE_LIMIT)
                                : drv[i];
            if (3'(i) < motor_count_reg)
                pwm[i] = jmpd_pkg::limit16(pwm[i], jmpd_pkg::NOMINAL_LIMIT);
        end
        out_data_next.motor_pwm_0  = pwm[0];
        out_data_next.motor_pwm_1  = pwm[1];
        out_data_next.motor_pwm_2  = pwm[2];
        out_data_next.motor_pwm_3  = pwm[3];
        out_data_next.stopped_mask = stop_bits;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/jmpd_checker.sv -----
// ----------------------------------------------------------------------------
// jmpd_checker
// Port-level checks on the joint-to-motor PWM decoupler, bound to the top
// level.
// ----------------------------------------------------------------------------
module jmpd_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input jmpd_pkg::out_t out_data
);

    // A result held by the receiver stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The block only pushes back when a finished result is stuck.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // A stopped motor always reads zero.
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (!out_data.stopped_mask[0] || out_data.motor_pwm_0 == 16'sd0) &&
            (!out_data.stopped_mask[1] || out_data.motor_pwm_1 == 16'sd0) &&
            (!out_data.stopped_mask[2] || out_data.motor_pwm_2 == 16'sd0) &&
            (!out_data.stopped_mask[3] || out_data.motor_pwm_3 == 16'sd0))
        else $error("stopped motor has a non-zero command");

    // No stall comes back while the output register is free.
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output register");

endmodule

bind joint_to_motor_pwm_decoupler jmpd_checker u_jmpd_checker (.*);
